// File: src/tss_pkg.sv
// ----------------------------------------------------------------------------
// tss_pkg: shared types and constants of the scanline span block
// word formats of the command and result channels, register map, limits
// ----------------------------------------------------------------------------
package tss_pkg;

	localparam int FIELD_BITS = 12;
	localparam int ROW_BITS   = 11;
	localparam int REG_BITS   = 12;
	localparam int SPAN_MAX   = 2047;

	localparam logic [REG_BITS-1:0] WIDTH_RESET  = 12'd480;
	localparam logic [REG_BITS-1:0] HEIGHT_RESET = 12'd272;

	// register index, taken from paddr[2]
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef struct packed {
		logic signed [FIELD_BITS-1:0] ax;
		logic signed [FIELD_BITS-1:0] ay;
		logic signed [FIELD_BITS-1:0] bx;
		logic signed [FIELD_BITS-1:0] by;
		logic signed [FIELD_BITS-1:0] cx;
		logic signed [FIELD_BITS-1:0] cy;
		logic [ROW_BITS-1:0]          row;
		logic [31:0]                  fill_color;
	} tss_in_t;

	typedef struct packed {
		logic                span_valid;
		logic [ROW_BITS-1:0] span_row;
		logic [ROW_BITS-1:0] span_left;
		logic [ROW_BITS-1:0] span_right;
		logic [31:0]         span_color;
	} tss_out_t;

	// per-word control that rides along the pipe
	typedef struct packed {
		logic                hit;
		logic [ROW_BITS-1:0] row;
		logic [31:0]         color;
	} tss_side_t;

endpackage

// File: src/tss_div_cell.sv
// ----------------------------------------------------------------------------
// tss_div_cell: one restoring division cell
// resolves quotient bit K and hands remainder, divisor and quotient onward
// ----------------------------------------------------------------------------
module tss_div_cell #(
	parameter int CB = 12,
	parameter int K  = 0
) (
	input  logic              clk,
	input  logic [2*CB+1:0]   rem_i,
	input  logic [CB:0]       dvs_i,
	input  logic [CB:0]       quo_i,
	output logic [2*CB+1:0]   rem_o,
	output logic [CB:0]       dvs_o,
	output logic [CB:0]       quo_o
);
	localparam int AW = 2 * CB + 2;

	logic [AW:0]   shifted;
	logic [AW:0]   diff;
	logic          take;
	logic [AW-1:0] rem_n;
	logic [CB:0]   quo_n;
	logic [AW-1:0] rem_q;
	logic [CB:0]   dvs_q;
	logic [CB:0]   quo_q;

	// trial subtract of the divisor at this bit weight
	always_comb begin
		shifted  = (AW + 1)'(dvs_i) << K;
		diff     = {1'b0, rem_i} - shifted;
		take     = ~diff[AW];
		rem_n    = take ? diff[AW-1:0] : rem_i;
		quo_n    = quo_i;
		quo_n[K] = take;
	end

	always_ff @(posedge clk) begin
		rem_q <= rem_n;
		dvs_q <= dvs_i;
		quo_q <= quo_n;
	end

	assign rem_o = rem_q;
	assign dvs_o = dvs_q;
	assign quo_o = quo_q;

endmodule

// File: src/tss_edge_setup.sv
// ----------------------------------------------------------------------------
// tss_edge_setup: vertex sort and edge setup
// sorts by y, picks long and short edge, forms dividend magnitude and sign
// ----------------------------------------------------------------------------
module tss_edge_setup #(
	parameter int CB = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  tss_pkg::tss_in_t             cmd,
	input  logic [tss_pkg::REG_BITS-1:0] height,
	output logic                         out_valid,
	output tss_pkg::tss_side_t           side,
	output logic signed [CB-1:0]         x0_long,
	output logic signed [CB-1:0]         x0_short,
	output logic [2*CB+1:0]              rem_long,
	output logic [2*CB+1:0]              rem_short,
	output logic [CB:0]                  dvs_long,
	output logic [CB:0]                  dvs_short,
	output logic                         neg_long,
	output logic                         neg_short
);
	import tss_pkg::*;

	localparam int W  = (CB + 2 > ROW_BITS + 2) ? CB + 2 : ROW_BITS + 2;
	localparam int AW = 2 * CB + 2;
	localparam int PW = 2 * CB + 2;
	localparam int NW = 2 * CB + 4;

	function automatic logic signed [CB-1:0] coord(input logic signed [FIELD_BITS-1:0] f);
		logic signed [15:0] e;
		e = 16'(f);
		return e[CB-1:0];
	endfunction

	logic signed [CB-1:0] x1, y1, x2, y2, x3, y3;
	logic signed [CB-1:0] t;
	logic signed [W-1:0]  rw, y1w, y2w, y3w, numl_w, nums_w;
	logic                 hit, upper, flat;
	logic signed [CB:0]   dxl, dxs, denl_w, dens_w;
	logic signed [CB-1:0] x0s;
	logic [CB-1:0]        numl, nums, denl, dens;

	logic                 valid_s1, valid_s2, valid_s3;
	tss_side_t            side_s1, side_s2, side_s3;
	logic signed [CB-1:0] x0l_s1, x0s_s1, x0l_s2, x0s_s2, x0l_s3, x0s_s3;
	logic signed [CB:0]   dxl_s1, dxs_s1;
	logic [CB-1:0]        numl_s1, nums_s1, denl_s1, dens_s1, denl_s2, dens_s2;
	logic signed [PW-1:0] pl_s2, ps_s2;
	logic signed [NW-1:0] nl, ns;
	logic signed [NW-1:0] al, as_n;
	logic [AW-1:0]        reml_s3, rems_s3;
	logic [CB:0]          dvsl_s3, dvss_s3;
	logic                 negl_s3, negs_s3;

	// sort by y with three strict compare-swaps, then edge setup
	always_comb begin
		t  = '0;
		x1 = coord(cmd.ax); y1 = coord(cmd.ay);
		x2 = coord(cmd.bx); y2 = coord(cmd.by);
		x3 = coord(cmd.cx); y3 = coord(cmd.cy);
		if (y1 > y2) begin
			t = y1; y1 = y2; y2 = t;
			t = x1; x1 = x2; x2 = t;
		end
		if (y1 > y3) begin
			t = y1; y1 = y3; y3 = t;
			t = x1; x1 = x3; x3 = t;
		end
		if (y2 > y3) begin
			t = y2; y2 = y3; y3 = t;
			t = x2; x2 = x3; x3 = t;
		end
		rw  = signed'({{(W-ROW_BITS){1'b0}}, cmd.row});
		y1w = W'(y1);
		y2w = W'(y2);
		y3w = W'(y3);
		hit = (y3 != y1) && (rw >= y1w) && (rw <= y3w) && ({1'b0, cmd.row} < height);
		upper = (rw <= y2w) && (y2 > y1);
		flat  = (y3 == y2);

		dxl    = (CB + 1)'(x3) - (CB + 1)'(x1);
		numl_w = rw - y1w;
		denl_w = (CB + 1)'(y3) - (CB + 1)'(y1);

		priority if (upper) begin
			x0s    = x1;
			dxs    = (CB + 1)'(x2) - (CB + 1)'(x1);
			nums_w = rw - y1w;
			dens_w = (CB + 1)'(y2) - (CB + 1)'(y1);
		end else if (flat) begin
			x0s    = x2;
			dxs    = '0;
			nums_w = '0;
			dens_w = (CB + 1)'(1);
		end else begin
			x0s    = x2;
			dxs    = (CB + 1)'(x3) - (CB + 1)'(x2);
			nums_w = rw - y2w;
			dens_w = (CB + 1)'(y3) - (CB + 1)'(y2);
		end

		numl = numl_w[CB-1:0];
		nums = nums_w[CB-1:0];
		denl = denl_w[CB-1:0];
		dens = dens_w[CB-1:0];
		// no span: keep the dividers on a harmless word
		if (!hit) begin
			dxl  = '0; dxs  = '0;
			numl = '0; nums = '0;
			denl = CB'(1); dens = CB'(1);
		end
	end

	// dividend 2*dx*num + den, sign and magnitude
	always_comb begin
		nl   = {pl_s2[PW-1], pl_s2, 1'b0} + NW'({1'b0, denl_s2});
		ns   = {ps_s2[PW-1], ps_s2, 1'b0} + NW'({1'b0, dens_s2});
		al   = nl[NW-1] ? -nl : nl;
		as_n = ns[NW-1] ? -ns : ns;
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// payload pipe
	always_ff @(posedge clk) begin
		side_s1 <= '{hit: hit, row: cmd.row, color: cmd.fill_color};
		x0l_s1  <= x1;
		x0s_s1  <= x0s;
		dxl_s1  <= dxl;
		dxs_s1  <= dxs;
		numl_s1 <= numl;
		nums_s1 <= nums;
		denl_s1 <= denl;
		dens_s1 <= dens;

		side_s2 <= side_s1;
		x0l_s2  <= x0l_s1;
		x0s_s2  <= x0s_s1;
		pl_s2   <= PW'(dxl_s1) * PW'($signed({1'b0, numl_s1}));
		ps_s2   <= PW'(dxs_s1) * PW'($signed({1'b0, nums_s1}));
		denl_s2 <= denl_s1;
		dens_s2 <= dens_s1;

		side_s3 <= side_s2;
		x0l_s3  <= x0l_s2;
		x0s_s3  <= x0s_s2;
		reml_s3 <= al[AW-1:0];
		rems_s3 <= as_n[AW-1:0];
		dvsl_s3 <= {denl_s2, 1'b0};
		dvss_s3 <= {dens_s2, 1'b0};
		negl_s3 <= nl[NW-1];
		negs_s3 <= ns[NW-1];
	end

	assign out_valid = valid_s3;
	assign side      = side_s3;
	assign x0_long   = x0l_s3;
	assign x0_short  = x0s_s3;
	assign rem_long  = reml_s3;
	assign rem_short = rems_s3;
	assign dvs_long  = dvsl_s3;
	assign dvs_short = dvss_s3;
	assign neg_long  = negl_s3;
	assign neg_short = negs_s3;

endmodule

// File: src/triangle_scanline_span.sv
// ----------------------------------------------------------------------------
// triangle_scanline_span: horizontal fill span of a triangle on one row
// sorted-vertex edge interpolation through a chain of divider cells
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a word (three vertices, row, colour) is taken at each
//   rising edge with start high and busy low. busy is always low, so a new
//   word may be issued every cycle.
//   Result channel: each command gives exactly one result word, shown on
//   result for one cycle with done high. The receiver cannot stall; results
//   leave in command order.
//   Pipeline: three setup stages (sort, multiply, sign/magnitude), one divider
//   cell per quotient bit (COORD_BITS + 1) and two span stages lie between
//   acceptance and done.
//   Throughput: one word per cycle; every cell of both edge chains works on
//   a different word each cycle.
//   Config: APB port, screen_width at 0x0, screen_height at 0x4, written at
//   the access cycle, readable; write only while no word is in flight.
//   Reset: asynchronous, low active; clears the pipe valid bits and loads
//   width 480 and height 272.
// ----------------------------------------------------------------------------
module triangle_scanline_span #(
	parameter int COORD_BITS = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  tss_pkg::tss_in_t cmd,
	output logic             done,
	output tss_pkg::tss_out_t result,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import tss_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int AW = 2 * CB + 2;
	localparam int QB = CB + 1;
	localparam int XW = CB + 3;
	localparam int EW = ((XW > ROW_BITS + 2) ? XW : ROW_BITS + 2) + 1;

	logic [REG_BITS-1:0] width_q, height_q;
	logic                wr_en;

	logic                 set_valid;
	tss_side_t            set_side;
	logic signed [CB-1:0] set_x0l, set_x0s;
	logic                 set_negl, set_negs;

	logic [AW-1:0] rem_l [QB+1];
	logic [AW-1:0] rem_s [QB+1];
	logic [CB:0]   dvs_l [QB+1];
	logic [CB:0]   dvs_s [QB+1];
	logic [CB:0]   quo_l [QB+1];
	logic [CB:0]   quo_s [QB+1];

	logic                 valid_q [QB];
	tss_side_t            side_q  [QB];
	logic signed [CB-1:0] x0l_q   [QB];
	logic signed [CB-1:0] x0s_q   [QB];
	logic                 negl_q  [QB];
	logic                 negs_q  [QB];

	logic signed [CB+1:0] qvl, qvs, qsl, qss;
	logic                 valid_s4;
	tss_side_t            side_s4;
	logic signed [XW-1:0] xl_s4, xs_s4;

	logic signed [EW-1:0] xa, xb, wl, xl_e, xs_e;
	logic                 ok;
	logic                 done_q;
	tss_out_t             result_q;

	// configuration registers
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_WIDTH:  width_q  <= pwdata[REG_BITS-1:0];
				REG_HEIGHT: height_q <= pwdata[REG_BITS-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_WIDTH:  prdata = {{(32-REG_BITS){1'b0}}, width_q};
			REG_HEIGHT: prdata = {{(32-REG_BITS){1'b0}}, height_q};
			default:    prdata = '0;
		endcase
	end

	assign busy = 1'b0;

	// sort and edge setup
	tss_edge_setup #(.CB(CB)) u_setup (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.cmd       (cmd),
		.height    (height_q),
		.out_valid (set_valid),
		.side      (set_side),
		.x0_long   (set_x0l),
		.x0_short  (set_x0s),
		.rem_long  (rem_l[0]),
		.rem_short (rem_s[0]),
		.dvs_long  (dvs_l[0]),
		.dvs_short (dvs_s[0]),
		.neg_long  (set_negl),
		.neg_short (set_negs)
	);

	assign quo_l[0] = '0;
	assign quo_s[0] = '0;

	// divider cell chains, most significant quotient bit first
	for (genvar j = 0; j < QB; j++) begin : g_cell
		tss_div_cell #(.CB(CB), .K(QB - 1 - j)) u_long (
			.clk   (clk),
			.rem_i (rem_l[j]),
			.dvs_i (dvs_l[j]),
			.quo_i (quo_l[j]),
			.rem_o (rem_l[j+1]),
			.dvs_o (dvs_l[j+1]),
			.quo_o (quo_l[j+1])
		);
		tss_div_cell #(.CB(CB), .K(QB - 1 - j)) u_short (
			.clk   (clk),
			.rem_i (rem_s[j]),
			.dvs_i (dvs_s[j]),
			.quo_i (quo_s[j]),
			.rem_o (rem_s[j+1]),
			.dvs_o (dvs_s[j+1]),
			.quo_o (quo_s[j+1])
		);
	end

	// side line in step with the cells
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QB; i++) valid_q[i] <= 1'b0;
		end else begin
			valid_q[0] <= set_valid;
			for (int i = 1; i < QB; i++) valid_q[i] <= valid_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		side_q[0] <= set_side;
		x0l_q[0]  <= set_x0l;
		x0s_q[0]  <= set_x0s;
		negl_q[0] <= set_negl;
		negs_q[0] <= set_negs;
		for (int i = 1; i < QB; i++) begin
			side_q[i] <= side_q[i-1];
			x0l_q[i]  <= x0l_q[i-1];
			x0s_q[i]  <= x0s_q[i-1];
			negl_q[i] <= negl_q[i-1];
			negs_q[i] <= negs_q[i-1];
		end
	end

	// signed quotient plus start x gives each edge x
	always_comb begin
		qvl = signed'({1'b0, quo_l[QB]});
		qvs = signed'({1'b0, quo_s[QB]});
		qsl = negl_q[QB-1] ? -qvl : qvl;
		qss = negs_q[QB-1] ? -qvs : qvs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_q[QB-1];
		end
	end

	always_ff @(posedge clk) begin
		side_s4 <= side_q[QB-1];
		xl_s4   <= XW'(x0l_q[QB-1]) + XW'(qsl);
		xs_s4   <= XW'(x0s_q[QB-1]) + XW'(qss);
	end

	// order the ends, clip to the screen
	always_comb begin
		xl_e = EW'(xl_s4);
		xs_e = EW'(xs_s4);
		wl   = signed'(EW'({1'b0, width_q})) - EW'(1);
		xa   = (xl_e < xs_e) ? xl_e : xs_e;
		xb   = (xl_e < xs_e) ? xs_e : xl_e;
		if (xa < 0) xa = '0;
		if (xb > wl) xb = wl;
		if (xb > EW'(SPAN_MAX)) xb = EW'(SPAN_MAX);
		ok = side_s4.hit && (xa <= xb);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		result_q.span_valid <= ok;
		result_q.span_row   <= side_s4.row;
		result_q.span_left  <= ok ? xa[ROW_BITS-1:0] : '0;
		result_q.span_right <= ok ? xb[ROW_BITS-1:0] : '0;
		result_q.span_color <= side_s4.color;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// File: bench/triangle_scanline_span_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_scanline_span_tb: self-checking bench of the scanline span block
// drives vertex/row words at random spacing, predicts each span word from a
// directed table or a local model of sort and edge interpolation, and checks
// the result stream in order; screen size registers are reprogrammed between phases
// ----------------------------------------------------------------------------
module triangle_scanline_span_tb;
	import tss_pkg::*;

	localparam int LATENCY = 18;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	tss_in_t     cmd;
	logic        done;
	tss_out_t    result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	triangle_scanline_span dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	// local copy of the screen size
	int unsigned scr_w;
	int unsigned scr_h;

	tss_out_t span_q[$];
	int       n_err;

	typedef struct {
		tss_in_t  word;
		bit       fixed;
		tss_out_t want;
	} stim_t;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		#50ms;
		$display("TEST FAILED");
		$finish;
	end

	// rounded edge x, truncating division
	function automatic longint edge_at(longint x0, longint dx, longint num, longint den);
		return x0 + (2 * dx * num + den) / (2 * den);
	endfunction

	function automatic tss_out_t span_of(tss_in_t w);
		longint   x1, y1, x2, y2, x3, y3, t, r, lx, sx, xa, xb;
		tss_out_t o;
		x1 = longint'(w.ax); y1 = longint'(w.ay);
		x2 = longint'(w.bx); y2 = longint'(w.by);
		x3 = longint'(w.cx); y3 = longint'(w.cy);
		r = longint'(w.row);
		o = '0;
		o.span_row = w.row;
		o.span_color = w.fill_color;
		if (y1 > y2) begin
			t = y1; y1 = y2; y2 = t; t = x1; x1 = x2; x2 = t;
		end
		if (y1 > y3) begin
			t = y1; y1 = y3; y3 = t; t = x1; x1 = x3; x3 = t;
		end
		if (y2 > y3) begin
			t = y2; y2 = y3; y3 = t; t = x2; x2 = x3; x3 = t;
		end
		if (y3 != y1 && r >= y1 && r <= y3 && r < longint'(scr_h)) begin
			lx = edge_at(x1, x3 - x1, r - y1, y3 - y1);
			if (r <= y2 && y2 > y1)
				sx = edge_at(x1, x2 - x1, r - y1, y2 - y1);
			else if (y3 == y2)
				sx = x2;
			else
				sx = edge_at(x2, x3 - x2, r - y2, y3 - y2);
			xa = lx < sx ? lx : sx;
			xb = lx < sx ? sx : lx;
			if (xa < 0)
				xa = 0;
			if (xb >= longint'(scr_w))
				xb = longint'(scr_w) - 1;
			if (xb > SPAN_MAX)
				xb = SPAN_MAX;
			if (xa <= xb) begin
				o.span_valid = 1'b1;
				o.span_left = xa[ROW_BITS-1:0];
				o.span_right = xb[ROW_BITS-1:0];
			end
		end
		return o;
	endfunction

	// result word check against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			tss_out_t exp_w;
			if (span_q.size() == 0) begin
				n_err++;
				if (n_err <= 10)
					$display("unexpected word %h", result);
			end else begin
				exp_w = span_q.pop_front();
				if (result.span_valid !== exp_w.span_valid ||
						result.span_row !== exp_w.span_row ||
						result.span_left !== exp_w.span_left ||
						result.span_right !== exp_w.span_right ||
						result.span_color !== exp_w.span_color) begin
					n_err++;
					if (n_err <= 10)
						$display("mismatch: exp v%0d r%0d l%0d r%0d c%h got v%0d r%0d l%0d r%0d c%h",
							exp_w.span_valid, exp_w.span_row, exp_w.span_left,
							exp_w.span_right, exp_w.span_color, result.span_valid,
							result.span_row, result.span_left, result.span_right,
							result.span_color);
				end
			end
		end
	end

	// setup and access cycle, then the bus returns to idle
	task automatic reg_write(logic idx, int unsigned val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_WIDTH)
			scr_w = val & 12'hfff;
		else
			scr_h = val & 12'hfff;
		@(negedge clk);
	endtask

	task automatic drain_spans();
		while (span_q.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	// issue one word, then a random gap that may be zero; start stays high across words only where the gap is zero
	task automatic issue(tss_in_t w, bit fixed, tss_out_t want);
		int gap;
		start <= 1'b1;
		cmd <= w;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		span_q.push_back(fixed ? want : span_of(w));
		@(negedge clk);
		gap = ($urandom_range(0, 9) < 6) ? 0 :
			(($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40));
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	function automatic logic signed [FIELD_BITS-1:0] coord(int lo, int hi);
		return FIELD_BITS'($urandom_range(hi - lo) + lo);
	endfunction

	// mostly triangles straddling the queried row, some raw noise
	function automatic tss_in_t rand_word();
		tss_in_t w;
		int      mode;
		w.fill_color = $urandom;
		mode = $urandom_range(0, 9);
		if (mode < 2) begin
			w.ax = FIELD_BITS'($urandom); w.ay = FIELD_BITS'($urandom);
			w.bx = FIELD_BITS'($urandom); w.by = FIELD_BITS'($urandom);
			w.cx = FIELD_BITS'($urandom); w.cy = FIELD_BITS'($urandom);
			w.row = ROW_BITS'($urandom);
		end else begin
			w.row = (mode == 2) ? ROW_BITS'($urandom) : ROW_BITS'($urandom_range(0, scr_h + 8));
			w.ay = coord(int'(w.row) - 300, int'(w.row) + 20);
			w.by = coord(int'(w.row) - 300, int'(w.row) + 300);
			w.cy = (mode == 3) ? w.by : coord(int'(w.row) - 20, int'(w.row) + 300);
			w.ax = coord(-300, scr_w + 300);
			w.bx = coord(-300, scr_w + 300);
			w.cx = (mode == 4) ? coord(-2048, 2047) : coord(-300, scr_w + 300);
		end
		return w;
	endfunction

	function automatic tss_in_t mk(int ax, int ay, int bx, int by, int cx, int cy, int row,
			int unsigned col);
		tss_in_t w;
		w.ax = FIELD_BITS'(ax); w.ay = FIELD_BITS'(ay);
		w.bx = FIELD_BITS'(bx); w.by = FIELD_BITS'(by);
		w.cx = FIELD_BITS'(cx); w.cy = FIELD_BITS'(cy);
		w.row = ROW_BITS'(row); w.fill_color = col;
		return w;
	endfunction

	function automatic tss_out_t res(bit v, int row, int l, int r, int unsigned col);
		tss_out_t o;
		o.span_valid = v; o.span_row = ROW_BITS'(row);
		o.span_left = ROW_BITS'(l); o.span_right = ROW_BITS'(r);
		o.span_color = col;
		return o;
	endfunction

	initial begin
		stim_t    dir[$];
		int       phase_w[5] = '{480, 1, 2048, 4095, 0};
		int       phase_h[5] = '{272, 2048, 1, 4095, 0};
		int       k;
		tss_in_t  w;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		n_err = 0;
		scr_w = WIDTH_RESET;
		scr_h = HEIGHT_RESET;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table at reset screen size
		dir.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 32'h0), 1, res(0, 0, 0, 0, 32'h0)});
		dir.push_back('{mk(0, 5, 10, 5, 20, 5, 5, 32'hffffffff), 1, res(0, 5, 0, 0, 32'hffffffff)});
		dir.push_back('{mk(0, 0, 10, 0, 0, 10, 0, 32'h1), 1, res(1, 0, 0, 10, 32'h1)});
		dir.push_back('{mk(0, 0, 10, 0, 0, 10, 11, 32'h2), 1, res(0, 11, 0, 0, 32'h2)});
		dir.push_back('{mk(-2048, -2048, 2047, -2048, 0, 2047, 100, 32'ha5a5a5a5), 0, '0});
		dir.push_back('{mk(-2048, 0, 2047, 2047, 2047, -2048, 0, 32'h5a5a5a5a), 1,
			res(1, 0, 0, 479, 32'h5a5a5a5a)});
		dir.push_back('{mk(0, 0, 100, 2047, 50, 2047, 2047, 32'h3), 1, res(0, 2047, 0, 0, 32'h3)});
		dir.push_back('{mk(5, 20, 0, 0, 40, 20, 20, 32'h4), 0, '0});
		dir.push_back('{mk(5, 20, 0, 0, 40, 20, 15, 32'h5), 0, '0});
		dir.push_back('{mk(3, 30, 60, 10, 9, -5, 25, 32'h6), 0, '0});
		dir.push_back('{mk(-100, 0, -50, 5, -80, 10, 4, 32'h7), 1, res(0, 4, 0, 0, 32'h7)});
		dir.push_back('{mk(600, 0, 700, 5, 650, 10, 4, 32'h8), 1, res(0, 4, 0, 0, 32'h8)});
		dir.push_back('{mk(0, 0, 13, 7, -9, 3, 3, 32'h9), 0, '0});
		dir.push_back('{mk(0, 0, 13, 7, -9, 3, 271, 32'ha), 0, '0});
		dir.push_back('{mk(-1, 300, 1, 250, 0, 260, 271, 32'hb), 0, '0});
		foreach (dir[i])
			issue(dir[i].word, dir[i].fixed, dir[i].want);
		start <= 1'b0;
		drain_spans();

		// random phases across screen sizes, extremes included
		for (int p = 0; p < 5; p++) begin
			reg_write(REG_WIDTH, phase_w[p]);
			reg_write(REG_HEIGHT, phase_h[p]);
			if (p == 3)
				reg_write(REG_HEIGHT, 32'hffff_f000 | $urandom_range(1, 2048));
			for (k = 0; k < ((p == 4) ? 50 : 250); k++) begin
				w = rand_word();
				issue(w, 0, '0);
				if (k == 120) begin
					start <= 1'b0;
					while (span_q.size() != 0)
						@(negedge clk);
				end
			end
			start <= 1'b0;
			drain_spans();
		end

		if (n_err == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
